// ----- rtl/core/ehb_pkg.sv -----
// ----------------------------------------------------------------------------
// ehb_pkg
// shared widths, constants and the per-byte hash update of the elf hash block
// ----------------------------------------------------------------------------
package ehb_pkg;

  localparam int unsigned HashW      = 28;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BucketBits = 20;
  localparam int unsigned CountW     = 21;
  localparam int unsigned RemW       = BucketBits;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned StepW      = $clog2(HashW);

  localparam logic [CountW-1:0] CountReset = CountW'(1024);
  localparam logic [CountW-1:0] DivLimit   = CountW'(1) << BucketBits;
  localparam logic [StepW-1:0]  LastStep   = StepW'(HashW - 1);

  typedef logic [HashW-1:0] hash_t;

  // one word handed from the front to the back through the queue
  typedef struct packed {
    logic  valid;
    hash_t hash;
  } key_word_t;

  // shift in one byte, fold the top nibble back in at bits 4..7, drop it
  function automatic hash_t hash_update(hash_t h, logic [ByteW-1:0] c);
    logic [31:0] t;
    logic [3:0]  top;
    t      = {h, 4'b0000} + {24'b0, c};
    top    = t[31:28];
    t[7:4] = t[7:4] ^ top;
    return t[HashW-1:0];
  endfunction

endpackage

// ----- rtl/core/ehb_front.sv -----
// ----------------------------------------------------------------------------
// ehb_front
// takes key bytes, keeps the running hash, hands finished hashes to the queue
// ----------------------------------------------------------------------------
module ehb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [ehb_pkg::ByteW-1:0]   char_byte_i,
  input  logic                        q_full_i,
  output ehb_pkg::key_word_t          q_word_o
);

  ehb_pkg::hash_t run_q, run_d;
  logic           accept;
  logic           term;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign term   = (char_byte_i == '0);

  assign q_word_o.valid = accept && term;
  assign q_word_o.hash  = run_q;

  always_comb begin
    run_d = run_q;
    if (accept) begin
      run_d = term ? '0 : ehb_pkg::hash_update(run_q, char_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

// ----- rtl/core/ehb_queue.sv -----
// ----------------------------------------------------------------------------
// ehb_queue
// short queue of finished hashes between the front and the divider
// ----------------------------------------------------------------------------
module ehb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ehb_pkg::key_word_t   wr_word_i,
  output logic                 full_o,
  input  logic                 rd_i,
  output logic                 empty_o,
  output ehb_pkg::hash_t       rd_data_o
);

  ehb_pkg::hash_t                  mem_q [ehb_pkg::QueueDepth];
  logic [ehb_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [ehb_pkg::QueueCntW-1:0]   cnt_q;
  logic                            do_wr, do_rd;

  assign full_o    = (cnt_q == ehb_pkg::QueueCntW'(ehb_pkg::QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_word_i.valid && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_word_i.hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/ehb_back.sv -----
// ----------------------------------------------------------------------------
// ehb_back
// restoring divider, one quotient bit a cycle (the last step waits for a free result register), and the result register
// ----------------------------------------------------------------------------
module ehb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ehb_pkg::CountW-1:0]     bucket_count_i,
  input  logic                           q_empty_i,
  input  ehb_pkg::hash_t                 q_data_i,
  output logic                           q_rd_o,
  input  logic                           pop,
  output logic                           empty,
  output logic [ehb_pkg::BucketBits-1:0] bucket_index_o,
  output logic [ehb_pkg::HashW-1:0]      hash_value_o
);

  logic                           busy_q;
  logic [ehb_pkg::StepW-1:0]      step_q;
  ehb_pkg::hash_t                 dvd_q, hash_q;
  logic [ehb_pkg::RemW-1:0]       rem_q;
  logic [ehb_pkg::CountW-1:0]     div_q, div_eff;
  logic                           out_valid_q, out_valid_d;
  logic [ehb_pkg::BucketBits-1:0] out_idx_q;
  ehb_pkg::hash_t                 out_hash_q;

  logic [ehb_pkg::RemW:0]         rem_sh, rem_nx;
  logic                           last, out_free, advance, start, finish;

  // zero divides as one, anything above the table size saturates
  always_comb begin
    priority if (bucket_count_i == '0) begin
      div_eff = ehb_pkg::CountW'(1);
    end else if (bucket_count_i > ehb_pkg::DivLimit) begin
      div_eff = ehb_pkg::DivLimit;
    end else begin
      div_eff = bucket_count_i;
    end
  end

  assign rem_sh   = {rem_q, dvd_q[ehb_pkg::HashW-1]};
  assign rem_nx   = (rem_sh >= div_q) ? rem_sh - div_q : rem_sh;
  assign last     = (step_q == ehb_pkg::LastStep);
  assign out_free = !out_valid_q || pop;
  assign advance  = busy_q && (!last || out_free);
  assign finish   = advance && last;
  assign start    = !busy_q && !q_empty_i;
  assign q_rd_o   = start;

  assign empty          = !out_valid_q;
  assign bucket_index_o = out_idx_q;
  assign hash_value_o   = out_hash_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      dvd_q  <= q_data_i;
      hash_q <= q_data_i;
      rem_q  <= '0;
      div_q  <= div_eff;
    end else if (advance) begin
      dvd_q <= {dvd_q[ehb_pkg::HashW-2:0], 1'b0};
      rem_q <= rem_nx[ehb_pkg::RemW-1:0];
    end
    if (finish) begin
      out_idx_q  <= rem_nx[ehb_pkg::BucketBits-1:0];
      out_hash_q <= hash_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (advance) begin
        step_q <= step_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/core/elf_string_hash_bucket_core.sv -----
// path: a key byte is taken into the running hash; a terminator's result shows
//   after the queue write, the divider load and 28 divider steps
// throughput: one byte per cycle while the queue is not full; the bit-serial divider
//   takes a new key only when done with the last, with a 4-word queue in front of it
// reset: running hash cleared, queue and result empty, bucket count 1024
// ----------------------------------------------------------------------------
// elf_string_hash_bucket_core
// elf hash of a zero-terminated key and its bucket index
// ----------------------------------------------------------------------------
module elf_string_hash_bucket_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [ehb_pkg::ByteW-1:0]      char_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [ehb_pkg::BucketBits-1:0] bucket_index_o,
  output logic [ehb_pkg::HashW-1:0]      hash_value_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ehb_pkg::CountW-1:0]     cfg_data_i
);

  logic [ehb_pkg::CountW-1:0] count_q;
  ehb_pkg::key_word_t         q_word;
  logic                       q_full, q_empty, q_rd;
  ehb_pkg::hash_t             q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= ehb_pkg::CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  ehb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_byte_i (char_byte_i),
    .q_full_i    (q_full),
    .q_word_o    (q_word)
  );

  ehb_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_word_i (q_word),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .empty_o   (q_empty),
    .rd_data_o (q_data)
  );

  ehb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (count_q),
    .q_empty_i      (q_empty),
    .q_data_i       (q_data),
    .q_rd_o         (q_rd),
    .pop            (pop),
    .empty          (empty),
    .bucket_index_o (bucket_index_o),
    .hash_value_o   (hash_value_o)
  );

endmodule
